// ===== rtl/core/casl_instruction_executor_macros.svh =====
// Assertion macros shared by the checker files of the CASL II instruction executor.
// Both macros expect a signal named aclk in the including scope; CASL_ASSERT also expects aresetn.
`ifndef CASL_INSTRUCTION_EXECUTOR_MACROS_SVH
`define CASL_INSTRUCTION_EXECUTOR_MACROS_SVH

// Property checked on every clock edge outside of reset.
`define CASL_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// Property checked on every clock edge, reset included.
`define CASL_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge aclk) prop) else $error(msg);

`endif

// ===== rtl/core/casl_pkg.sv =====
// Shared types, constants and helper functions of the CASL II instruction executor.
// Used by every module of the block; depends on nothing else.
package casl_pkg;

    localparam int MEMORY_WORDS   = 4096;  // power of two
    localparam int WORD_BITS      = 16;
    localparam int REGISTER_COUNT = 8;

    localparam int MEM_ADDR_BITS  = $clog2(MEMORY_WORDS);
    localparam int REG_IDX_BITS   = $clog2(REGISTER_COUNT);
    localparam int SHIFT_BITS     = $clog2(WORD_BITS);
    localparam int PC_BITS        = 12;
    localparam int IN_TDATA_BITS  = 40;
    localparam int OUT_TDATA_BITS = 32;

    typedef logic [WORD_BITS-1:0]     word_t;
    typedef logic [MEM_ADDR_BITS-1:0] maddr_t;
    typedef logic [REG_IDX_BITS-1:0]  ridx_t;
    typedef logic [PC_BITS-1:0]       pc_t;
    typedef logic [4:0]               mode_t;

    localparam mode_t MODE_START = 5'd0;
    localparam mode_t MODE_LD    = 5'd1;
    localparam mode_t MODE_LAD   = 5'd2;
    localparam mode_t MODE_ST    = 5'd3;
    localparam mode_t MODE_ADDA  = 5'd4;
    localparam mode_t MODE_SUBA  = 5'd5;
    localparam mode_t MODE_AND   = 5'd6;
    localparam mode_t MODE_OR    = 5'd7;
    localparam mode_t MODE_XOR   = 5'd8;
    localparam mode_t MODE_SLA   = 5'd9;
    localparam mode_t MODE_SRA   = 5'd10;
    localparam mode_t MODE_CPA   = 5'd11;
    localparam mode_t MODE_JPL   = 5'd12;
    localparam mode_t MODE_JMI   = 5'd13;
    localparam mode_t MODE_JNZ   = 5'd14;
    localparam mode_t MODE_JZE   = 5'd15;
    localparam mode_t MODE_JUMP  = 5'd16;
    localparam mode_t MODE_RET   = 5'd17;
    localparam mode_t MODE_SKIP  = 5'd18;
    localparam mode_t MODE_MEMWR = 5'd19;

    // Input beat, first field in the highest bits.
    typedef struct packed {
        logic signed [15:0] immediate;
        logic [11:0]        address;
        logic               operand_is_register;
        logic [2:0]         src_reg;
        logic [2:0]         dest_reg;
        mode_t              mode;
    } in_beat_t;

    // Output beat, first field in the highest bits, padded to whole bytes.
    typedef struct packed {
        logic               pad;
        logic               halted_out;
        logic               zero_out;
        logic               sign_out;
        logic signed [15:0] result_word;
        pc_t                next_pc;
    } out_beat_t;

    // Architectural flip-flop state seen by the execute logic.
    typedef struct packed {
        pc_t  pc;
        logic sign;
        logic zero;
        logic halt;
    } arch_t;

    // Everything one executed instruction changes.
    typedef struct packed {
        logic        reg_we;
        ridx_t       reg_waddr;
        word_t       reg_wdata;
        logic        mem_we;
        maddr_t      mem_waddr;
        word_t       mem_wdata;
        arch_t       arch;
        logic [15:0] result;
    } exec_t;

    // Register number modulo REGISTER_COUNT, by repeated subtraction on three bits.
    function automatic ridx_t reg_index(logic [2:0] r);
        logic [4:0] v;
        v = 5'(r);
        for (int i = 0; i < 3; i++) begin
            if (v >= 5'(REGISTER_COUNT)) begin
                v = v - 5'(REGISTER_COUNT);
            end
        end
        return v[REG_IDX_BITS-1:0];
    endfunction

    // Memory address modulo MEMORY_WORDS.
    function automatic maddr_t mem_index(logic [11:0] a);
        logic [31:0] w;
        w = 32'(a);
        return w[MEM_ADDR_BITS-1:0];
    endfunction

    // Sign-extends the 16-bit immediate to a machine word.
    function automatic word_t imm_to_word(logic signed [15:0] v);
        logic signed [31:0] e;
        e = 32'(v);
        return e[WORD_BITS-1:0];
    endfunction

    // Low 16 bits of a machine word, zero-extended if the word is narrower.
    function automatic logic [15:0] word_to_field(word_t w);
        logic [31:0] z;
        z = 32'(w);
        return z[15:0];
    endfunction

endpackage

// ===== rtl/core/casl_regfile.sv =====
// General register file of the CASL II executor: two registered read ports, one write port.
// Entries read as zero until first written after reset. Depends on casl_pkg.
module casl_regfile (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             rd_en,
    input  casl_pkg::ridx_t  raddr_a,
    input  casl_pkg::ridx_t  raddr_b,
    output casl_pkg::word_t  rdata_a,
    output casl_pkg::word_t  rdata_b,
    input  logic             we,
    input  casl_pkg::ridx_t  waddr,
    input  casl_pkg::word_t  wdata
);

    casl_pkg::word_t                        ram_reg [casl_pkg::REGISTER_COUNT];
    logic [casl_pkg::REGISTER_COUNT-1:0]    valid_reg;
    casl_pkg::word_t                        rdata_a_reg;
    casl_pkg::word_t                        rdata_b_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            ram_reg[waddr] <= wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (we) begin
            valid_reg[waddr] <= 1'b1;
        end
    end

    // A write landing on the same edge as the read is passed straight through.
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            if (we && (waddr == raddr_a)) begin
                rdata_a_reg <= wdata;
            end else begin
                rdata_a_reg <= valid_reg[raddr_a] ? ram_reg[raddr_a] : '0;
            end
            if (we && (waddr == raddr_b)) begin
                rdata_b_reg <= wdata;
            end else begin
                rdata_b_reg <= valid_reg[raddr_b] ? ram_reg[raddr_b] : '0;
            end
        end
    end

    assign rdata_a = rdata_a_reg;
    assign rdata_b = rdata_b_reg;

endmodule

// ===== rtl/core/casl_dmem.sv =====
// Data memory of the CASL II executor: single-port write, registered read with write bypass.
// Contents are undefined until written. Depends on casl_pkg.
module casl_dmem (
    input  logic             aclk,
    input  logic             rd_en,
    input  casl_pkg::maddr_t raddr,
    output casl_pkg::word_t  rdata,
    input  logic             we,
    input  casl_pkg::maddr_t waddr,
    input  casl_pkg::word_t  wdata
);

    casl_pkg::word_t ram_reg [casl_pkg::MEMORY_WORDS];
    casl_pkg::word_t rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            ram_reg[waddr] <= wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rdata_reg <= (we && (waddr == raddr)) ? wdata : ram_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/core/casl_alu.sv =====
// Execute logic of the CASL II executor: computes register, memory, flag and PC updates.
// Purely combinational. Depends on casl_pkg.
module casl_alu (
    input  casl_pkg::in_beat_t instr,
    input  casl_pkg::word_t    dest_word,
    input  casl_pkg::word_t    src_word,
    input  casl_pkg::word_t    mem_word,
    input  casl_pkg::arch_t    arch,
    output casl_pkg::exec_t    ex
);

    casl_pkg::word_t              opnd;
    casl_pkg::word_t              nw;
    casl_pkg::word_t              shl_word;
    casl_pkg::word_t              sra_word;
    logic [15:0]                  count;
    logic                         count_big;
    logic [casl_pkg::SHIFT_BITS-1:0] sh;
    casl_pkg::pc_t                pc_plus1;
    casl_pkg::pc_t                pc_plus2;
    casl_pkg::pc_t                pc_plus3;
    logic                         writes_reg;

    assign opnd      = instr.operand_is_register ? src_word : mem_word;
    assign count     = instr.immediate;
    assign count_big = count >= 16'(casl_pkg::WORD_BITS);
    assign sh        = count[casl_pkg::SHIFT_BITS-1:0];
    assign shl_word  = count_big ? '0 : (dest_word << sh);
    assign sra_word  = count_big ? {casl_pkg::WORD_BITS{dest_word[casl_pkg::WORD_BITS-1]}}
                                 : casl_pkg::word_t'($signed(dest_word) >>> sh);
    assign pc_plus1  = arch.pc + casl_pkg::pc_t'(1);
    assign pc_plus2  = arch.pc + casl_pkg::pc_t'(2);
    assign pc_plus3  = arch.pc + casl_pkg::pc_t'(3);

    always_comb begin
        ex            = '0;
        ex.arch       = arch;
        ex.reg_waddr  = casl_pkg::reg_index(instr.dest_reg);
        ex.mem_waddr  = casl_pkg::mem_index(instr.address);
        ex.mem_wdata  = dest_word;
        nw            = dest_word;
        writes_reg    = 1'b0;
        if (!arch.halt) begin
            case (instr.mode)
                casl_pkg::MODE_START, casl_pkg::MODE_SKIP: begin
                    ex.arch.pc = pc_plus1;
                end
                casl_pkg::MODE_LD: begin
                    nw = opnd;
                    ex.arch.zero = (nw == '0);
                    writes_reg = 1'b1;
                    ex.arch.pc = pc_plus3;
                end
                casl_pkg::MODE_LAD: begin
                    nw = casl_pkg::imm_to_word(instr.immediate);
                    writes_reg = 1'b1;
                    ex.arch.pc = pc_plus3;
                end
                casl_pkg::MODE_ST: begin
                    ex.mem_we = 1'b1;
                    ex.result = casl_pkg::word_to_field(dest_word);
                    ex.arch.pc = pc_plus3;
                end
                casl_pkg::MODE_ADDA: begin
                    nw = dest_word + opnd;
                    ex.arch.zero = (nw == '0);
                    writes_reg = 1'b1;
                    ex.arch.pc = pc_plus3;
                end
                casl_pkg::MODE_SUBA, casl_pkg::MODE_AND, casl_pkg::MODE_OR,
                casl_pkg::MODE_XOR, casl_pkg::MODE_SLA, casl_pkg::MODE_SRA: begin
                    case (instr.mode)
                        casl_pkg::MODE_SUBA: nw = dest_word - opnd;
                        casl_pkg::MODE_AND:  nw = dest_word & opnd;
                        casl_pkg::MODE_OR:   nw = dest_word | opnd;
                        casl_pkg::MODE_XOR:  nw = dest_word ^ opnd;
                        casl_pkg::MODE_SLA:  nw = shl_word;
                        default:             nw = sra_word;
                    endcase
                    ex.arch.zero = (nw == '0);
                    ex.arch.sign = nw[casl_pkg::WORD_BITS-1];
                    writes_reg = 1'b1;
                    ex.arch.pc = pc_plus3;
                end
                casl_pkg::MODE_CPA: begin
                    ex.arch.sign = ($signed(dest_word) < $signed(opnd));
                    ex.arch.zero = (dest_word == opnd);
                    ex.arch.pc = pc_plus3;
                end
                casl_pkg::MODE_JPL: begin
                    ex.arch.pc = (!arch.sign && !arch.zero) ? instr.address : pc_plus2;
                end
                casl_pkg::MODE_JMI: begin
                    ex.arch.pc = arch.sign ? instr.address : pc_plus2;
                end
                casl_pkg::MODE_JNZ: begin
                    ex.arch.pc = !arch.zero ? instr.address : pc_plus2;
                end
                casl_pkg::MODE_JZE: begin
                    ex.arch.pc = arch.zero ? instr.address : pc_plus2;
                end
                casl_pkg::MODE_JUMP: begin
                    ex.arch.pc = instr.address;
                end
                casl_pkg::MODE_RET: begin
                    ex.arch.halt = 1'b1;
                end
                casl_pkg::MODE_MEMWR: begin
                    ex.mem_we    = 1'b1;
                    ex.mem_wdata = casl_pkg::imm_to_word(instr.immediate);
                    ex.result    = casl_pkg::word_to_field(ex.mem_wdata);
                end
                default: begin
                end
            endcase
        end
        ex.reg_we    = writes_reg;
        ex.reg_wdata = nw;
        if (writes_reg) begin
            ex.result = casl_pkg::word_to_field(nw);
        end
    end

endmodule

// ===== rtl/core/casl_instruction_executor.sv =====
// CASL II instruction executor. Each input beat carries one decoded instruction; each one
// produces exactly one output beat with the new program counter, the produced or stored word,
// the sign and zero flags and the halt mark. The block sustains one instruction per clock
// cycle unless the output side stalls. When a beat is taken the register file (two read
// ports) and the data memory are read; when the instruction retires the execute logic
// updates registers, memory, flags and program counter and loads the output register.
// Both memories pass a write from the same edge straight to their read data, so an
// instruction that depends on the one just before it sees the new value with no stall.
// The data memory holds no defined value until written; reading such a word gives an
// unspecified operand. The register file reads zero after reset. Once RET has halted the
// machine every later instruction leaves all state alone and reports result_word zero.
// Depends on casl_pkg, casl_regfile, casl_dmem and casl_alu.
module casl_instruction_executor (
    input  logic        aclk,
    input  logic        aresetn,
    // s_tdata, from bit 0 up: mode[4:0], dest_reg[7:5], src_reg[10:8],
    // operand_is_register[11], address[23:12], immediate[39:24]
    input  logic [39:0] s_tdata,
    input  logic        s_tvalid,
    output logic        s_tready,
    // m_tdata, from bit 0 up: next_pc[11:0], result_word[27:12], sign_out[28],
    // zero_out[29], halted_out[30], zero padding[31]
    output logic [31:0] m_tdata,
    output logic        m_tvalid,
    input  logic        m_tready
);

    casl_pkg::in_beat_t  s_beat;
    logic                s_fire;
    logic                s1_fire;

    // Execute stage: the instruction whose operands are being read back.
    logic                s1_valid_reg;
    casl_pkg::in_beat_t  s1_instr_reg;

    // Architectural flip-flop state.
    casl_pkg::arch_t     arch_reg;

    // Output register.
    logic                m_valid_reg;
    casl_pkg::out_beat_t m_beat_reg;
    casl_pkg::out_beat_t m_beat_next;

    casl_pkg::word_t     dest_word;
    casl_pkg::word_t     src_word;
    casl_pkg::word_t     mem_word;
    casl_pkg::exec_t     ex;

    assign s_beat   = casl_pkg::in_beat_t'(s_tdata);
    // The execute stage retires when the output register is free or is being emptied.
    assign s1_fire  = s1_valid_reg && (!m_valid_reg || m_tready);
    // No beat is taken while reset is held.
    assign s_tready = aresetn && (!s1_valid_reg || s1_fire);
    assign s_fire   = s_tvalid && s_tready;

    casl_regfile u_regfile (
        .aclk    (aclk),
        .aresetn (aresetn),
        .rd_en   (s_fire),
        .raddr_a (casl_pkg::reg_index(s_beat.dest_reg)),
        .raddr_b (casl_pkg::reg_index(s_beat.src_reg)),
        .rdata_a (dest_word),
        .rdata_b (src_word),
        .we      (s1_fire && ex.reg_we),
        .waddr   (ex.reg_waddr),
        .wdata   (ex.reg_wdata)
    );

    casl_dmem u_dmem (
        .aclk  (aclk),
        .rd_en (s_fire),
        .raddr (casl_pkg::mem_index(s_beat.address)),
        .rdata (mem_word),
        .we    (s1_fire && ex.mem_we),
        .waddr (ex.mem_waddr),
        .wdata (ex.mem_wdata)
    );

    casl_alu u_alu (
        .instr     (s1_instr_reg),
        .dest_word (dest_word),
        .src_word  (src_word),
        .mem_word  (mem_word),
        .arch      (arch_reg),
        .ex        (ex)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (s_fire) begin
            s1_valid_reg <= 1'b1;
        end else if (s1_fire) begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            s1_instr_reg <= s_beat;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            arch_reg <= '0;
        end else if (s1_fire) begin
            arch_reg <= ex.arch;
        end
    end

    always_comb begin
        m_beat_next             = '0;
        m_beat_next.next_pc     = ex.arch.pc;
        m_beat_next.result_word = ex.result;
        m_beat_next.sign_out    = ex.arch.sign;
        m_beat_next.zero_out    = ex.arch.zero;
        m_beat_next.halted_out  = ex.arch.halt;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (s1_fire) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s1_fire) begin
            m_beat_reg <= m_beat_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_beat_reg;

endmodule

// ===== rtl/core/casl_checker.sv =====
// Port-level checker for the CASL II instruction executor, bound to the top level.
// Depends on casl_pkg and casl_instruction_executor_macros.svh.
`include "casl_instruction_executor_macros.svh"

module casl_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic [31:0] m_tdata,
    input logic        m_tvalid,
    input logic        m_tready
);

    casl_pkg::out_beat_t m_beat;
    logic                in_fire;
    logic                out_fire;
    logic                m_stalled;
    logic                halted_beat;
    logic                halt_beat_ok;
    logic [1:0]          outstanding_reg;
    logic [1:0]          outstanding_next;
    logic                halt_seen_reg;
    casl_pkg::pc_t       halt_pc_reg;

    assign m_beat    = casl_pkg::out_beat_t'(m_tdata);
    assign in_fire   = s_tvalid && s_tready;
    assign out_fire  = m_tvalid && m_tready;
    assign m_stalled = m_tvalid && !m_tready;

    // After a halted beat every later beat repeats the halted state with a zero word.
    assign halted_beat  = m_tvalid && halt_seen_reg;
    assign halt_beat_ok = m_beat.halted_out && (m_beat.next_pc == halt_pc_reg) &&
                          (m_beat.result_word == 16'sd0);

    always_comb begin
        outstanding_next = outstanding_reg;
        if (in_fire && !out_fire) begin
            outstanding_next = outstanding_reg + 2'd1;
        end else if (out_fire && !in_fire) begin
            outstanding_next = outstanding_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            outstanding_reg <= 2'd0;
            halt_seen_reg   <= 1'b0;
            halt_pc_reg     <= '0;
        end else begin
            outstanding_reg <= outstanding_next;
            if (out_fire && m_beat.halted_out && !halt_seen_reg) begin
                halt_seen_reg <= 1'b1;
                halt_pc_reg   <= m_beat.next_pc;
            end
        end
    end

    `CASL_ASSERT_ALWAYS(a_reset_clears_output, !aresetn |=> !m_tvalid, "output valid after reset")
    `CASL_ASSERT(a_stall_holds, m_stalled |=> m_tvalid && $stable(m_tdata), "stalled beat changed")
    `CASL_ASSERT(a_no_invented_beat, m_tvalid |-> |outstanding_reg, "beat without instruction")
    `CASL_ASSERT(a_halt_is_final, halted_beat |-> halt_beat_ok, "halted machine changed state")

endmodule

bind casl_instruction_executor casl_checker u_casl_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tdata  (m_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready)
);

// ===== verif/casl_instruction_executor_tb.sv =====
// Self-checking testbench for the CASL II instruction executor.
// Depends on casl_pkg and casl_instruction_executor; predicts every result beat in place.
module casl_instruction_executor_tb;
    import casl_pkg::*;

    localparam int CYCLE_LIMIT = 100000;
    localparam int HOLD_OFF_CYCLES = 80;
    localparam int DRAIN_CYCLES = 10;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    // s_tdata, from bit 0 up: mode, dest_reg, src_reg, operand_is_register, address, immediate
    logic [39:0] s_tdata = '0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    // m_tdata, from bit 0 up: next_pc, result_word, sign_out, zero_out, halted_out, padding
    logic [31:0] m_tdata;
    logic        m_tvalid;
    logic        m_tready = 1'b0;

    casl_instruction_executor uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tdata  (m_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Machine state as the predictor sees it after every accepted instruction.
    word_t     gpr [REGISTER_COUNT];
    word_t     dmem [MEMORY_WORDS];
    bit        mem_written [MEMORY_WORDS];
    maddr_t    written_addrs [$];
    pc_t       cpu_pc;
    logic      cpu_sign;
    logic      cpu_zero;
    logic      cpu_halt;

    out_beat_t pending_results [$];
    int        error_count = 0;
    int        cycle_count = 0;
    int        send_idle_pct = 0;
    int        recv_idle_pct = 0;
    int        hold_cycles = 0;
    out_beat_t got_beat;
    out_beat_t want_beat;

    // Applies one instruction to the predicted machine and returns the beat it reports.
    function automatic out_beat_t execute_instr(in_beat_t b);
        word_t                 opnd;
        word_t                 d;
        word_t                 res;
        pc_t                   pc;
        logic [15:0]           shift_count;
        logic signed [WORD_BITS-1:0] sd;
        logic signed [WORD_BITS-1:0] so;
        out_beat_t             o;
        opnd = b.operand_is_register ? gpr[b.src_reg] : dmem[b.address];
        d = gpr[b.dest_reg];
        res = '0;
        pc = cpu_pc;
        shift_count = b.immediate;
        if (!cpu_halt) begin
            case (b.mode)
                MODE_START, MODE_SKIP: pc = pc + pc_t'(1);
                MODE_LD: begin
                    d = opnd;
                    cpu_zero = (d == '0);
                    pc = pc + pc_t'(3);
                end
                MODE_LAD: begin
                    d = b.immediate;
                    pc = pc + pc_t'(3);
                end
                MODE_ST, MODE_MEMWR: begin
                    res = (b.mode == MODE_ST) ? d : word_t'(b.immediate);
                    dmem[b.address] = res;
                    if (!mem_written[b.address]) begin
                        mem_written[b.address] = 1'b1;
                        written_addrs.push_back(b.address);
                    end
                    if (b.mode == MODE_ST) begin
                        pc = pc + pc_t'(3);
                    end
                end
                MODE_ADDA: begin
                    d = d + opnd;
                    cpu_zero = (d == '0);
                    pc = pc + pc_t'(3);
                end
                MODE_SUBA: d = d - opnd;
                MODE_AND:  d = d & opnd;
                MODE_OR:   d = d | opnd;
                MODE_XOR:  d = d ^ opnd;
                MODE_SLA: begin
                    if (shift_count >= WORD_BITS) begin
                        d = '0;
                    end else begin
                        d = d << shift_count;
                    end
                end
                MODE_SRA: begin
                    // The sign bit fills in from the top; long counts leave only sign bits.
                    if (shift_count >= WORD_BITS) begin
                        d = {WORD_BITS{d[WORD_BITS-1]}};
                    end else begin
                        sd = d;
                        sd = sd >>> shift_count;
                        d = sd;
                    end
                end
                MODE_CPA: begin
                    sd = d;
                    so = opnd;
                    cpu_sign = (sd < so);
                    cpu_zero = (sd == so);
                    pc = pc + pc_t'(3);
                end
                MODE_JPL:  pc = (!cpu_sign && !cpu_zero) ? pc_t'(b.address) : pc + pc_t'(2);
                MODE_JMI:  pc = cpu_sign ? pc_t'(b.address) : pc + pc_t'(2);
                MODE_JNZ:  pc = !cpu_zero ? pc_t'(b.address) : pc + pc_t'(2);
                MODE_JZE:  pc = cpu_zero ? pc_t'(b.address) : pc + pc_t'(2);
                MODE_JUMP: pc = b.address;
                MODE_RET:  cpu_halt = 1'b1;
                default: ;
            endcase
            // The subtract, logic and shift group sets both flags from the new word.
            if (b.mode >= MODE_SUBA && b.mode <= MODE_SRA) begin
                cpu_zero = (d == '0);
                cpu_sign = d[WORD_BITS-1];
                pc = pc + pc_t'(3);
            end
            if (b.mode == MODE_LD || b.mode == MODE_LAD ||
                (b.mode >= MODE_ADDA && b.mode <= MODE_SRA)) begin
                gpr[b.dest_reg] = d;
                res = d;
            end
            cpu_pc = pc;
        end
        o.pad = 1'b0;
        o.halted_out = cpu_halt;
        o.zero_out = cpu_zero;
        o.sign_out = cpu_sign;
        o.result_word = res;
        o.next_pc = cpu_pc;
        return o;
    endfunction

    function automatic in_beat_t make_instr(mode_t m, int rd, int rs, bit by_reg,
                                            int addr, int imm);
        in_beat_t b;
        b.mode = m;
        b.dest_reg = 3'(rd);
        b.src_reg = 3'(rs);
        b.operand_is_register = by_reg;
        b.address = 12'(addr);
        b.immediate = 16'(imm);
        return b;
    endfunction

    // Random instruction that never halts the machine and never reads an unwritten word.
    function automatic in_beat_t random_instr();
        in_beat_t b;
        int       pick;
        bit       uses_memory;
        b.dest_reg = 3'($urandom_range(7));
        b.src_reg = 3'($urandom_range(7));
        b.operand_is_register = 1'($urandom_range(1));
        b.address = 12'($urandom_range(4095));
        pick = $urandom_range(99);
        if (pick < 14) begin
            b.mode = MODE_MEMWR;
        end else if (pick < 18) begin
            b.mode = mode_t'($urandom_range(MODE_MEMWR + 1, mode_t'('1)));
        end else begin
            b.mode = mode_t'($urandom_range(MODE_START, MODE_SKIP));
            if (b.mode == MODE_RET) begin
                b.mode = MODE_ST;
            end
        end
        if ((b.mode == MODE_SLA || b.mode == MODE_SRA) && $urandom_range(3) != 0) begin
            b.immediate = 16'($urandom_range(WORD_BITS + 1));
        end else if ($urandom_range(9) == 0) begin
            case ($urandom_range(3))
                0: b.immediate = 16'h8000;
                1: b.immediate = 16'h7fff;
                2: b.immediate = 16'hffff;
                default: b.immediate = 16'h0000;
            endcase
        end else begin
            b.immediate = 16'($urandom);
        end
        case (b.mode)
            MODE_LD, MODE_ADDA, MODE_SUBA, MODE_AND, MODE_OR, MODE_XOR, MODE_CPA:
                uses_memory = !b.operand_is_register;
            default: uses_memory = 1'b0;
        endcase
        if (uses_memory) begin
            if (written_addrs.size() == 0) begin
                b.operand_is_register = 1'b1;
            end else begin
                b.address = written_addrs[$urandom_range(written_addrs.size() - 1)];
            end
        end
        return b;
    endfunction

    // Offers one instruction beat, with random idle cycles first, and predicts its result
    // once the block takes it. Valid stays high when the next call sends straight away.
    task automatic send_instr(in_beat_t b);
        @(negedge aclk);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tdata <= b;
        s_tvalid <= 1'b1;
        do begin
            @(posedge aclk);
        end while (!s_tready);
        pending_results.push_back(execute_instr(b));
    endtask

    function automatic void compare_field(string field, int unsigned want, int unsigned got);
        if (want != got) begin
            error_count++;
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
        end
    endfunction

    // The receiver stalls at random, or for a long counted stretch when one is requested.
    always @(negedge aclk) begin
        if (hold_cycles > 0) begin
            m_tready <= 1'b0;
            hold_cycles--;
        end else begin
            m_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Every accepted result beat is checked against the oldest prediction.
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end else if (aresetn && m_tvalid && m_tready) begin
            got_beat = m_tdata;
            if (pending_results.size() == 0) begin
                error_count++;
                $display("%0t: unexpected result beat, expected none, actual %0h",
                         $time, m_tdata);
            end else begin
                want_beat = pending_results.pop_front();
                compare_field("next_pc", 32'(want_beat.next_pc), 32'(got_beat.next_pc));
                compare_field("result_word", 32'(want_beat.result_word),
                              32'(got_beat.result_word));
                compare_field("sign_out", 32'(want_beat.sign_out), 32'(got_beat.sign_out));
                compare_field("zero_out", 32'(want_beat.zero_out), 32'(got_beat.zero_out));
                compare_field("halted_out", 32'(want_beat.halted_out),
                              32'(got_beat.halted_out));
            end
        end
    end

    task automatic test_start_and_skip();
        send_instr(make_instr(MODE_START, 0, 0, 1'b1, 0, 0));
        send_instr(make_instr(MODE_SKIP, 7, 7, 1'b0, 4095, -1));
        send_instr(make_instr(mode_t'(MODE_MEMWR + 1), 3, 4, 1'b1, 12, 5));
        send_instr(make_instr(mode_t'('1), 7, 7, 1'b1, 4095, -1));
    endtask

    // Memory writes at both ends of the address range with extreme words, then loads and a store.
    task automatic test_load_store();
        send_instr(make_instr(MODE_MEMWR, 0, 0, 1'b0, 4095, 16'h8000));
        send_instr(make_instr(MODE_MEMWR, 0, 0, 1'b0, 0, 16'h7fff));
        send_instr(make_instr(MODE_MEMWR, 0, 0, 1'b0, 12'haaa, -1));
        send_instr(make_instr(MODE_MEMWR, 0, 0, 1'b0, 12'h555, 0));
        send_instr(make_instr(MODE_LD, 7, 0, 1'b0, 4095, 0));
        send_instr(make_instr(MODE_LD, 1, 0, 1'b0, 12'h555, 0));
        send_instr(make_instr(MODE_LAD, 0, 0, 1'b1, 0, 16'h7fff));
        send_instr(make_instr(MODE_LAD, 2, 0, 1'b1, 0, -1));
        send_instr(make_instr(MODE_ST, 7, 0, 1'b0, 12'h123, 0));
    endtask

    // Signed overflow and wrap to zero, a register subtract, AND on a memory operand, OR and XOR on registers.
    task automatic test_arith_logic();
        send_instr(make_instr(MODE_ADDA, 0, 0, 1'b0, 0, 0));
        send_instr(make_instr(MODE_ADDA, 7, 7, 1'b1, 0, 0));
        send_instr(make_instr(MODE_SUBA, 1, 2, 1'b1, 0, 0));
        send_instr(make_instr(MODE_AND, 2, 0, 1'b0, 12'haaa, 0));
        send_instr(make_instr(MODE_OR, 3, 1, 1'b1, 0, 0));
        send_instr(make_instr(MODE_XOR, 2, 2, 1'b1, 0, 0));
    endtask

    // Shift counts of zero, the width, one below the width and a negative immediate, which counts as huge.
    task automatic test_shifts();
        send_instr(make_instr(MODE_LAD, 4, 0, 1'b1, 0, 16'h8001));
        send_instr(make_instr(MODE_SRA, 4, 0, 1'b1, 0, WORD_BITS));
        send_instr(make_instr(MODE_SRA, 0, 0, 1'b1, 0, 0));
        send_instr(make_instr(MODE_SLA, 3, 0, 1'b1, 0, WORD_BITS - 1));
        send_instr(make_instr(MODE_SLA, 4, 0, 1'b1, 0, 16'hffff));
    endtask

    // Compares give less, equal and greater; JPL is tried both ways, JMI, JNZ and JZE one way each,
    // and a jump to the last address lets the program counter wrap.
    task automatic test_compare_and_branch();
        send_instr(make_instr(MODE_CPA, 0, 0, 1'b0, 0, 0));
        send_instr(make_instr(MODE_JMI, 0, 0, 1'b1, 12'h800, 0));
        send_instr(make_instr(MODE_JPL, 0, 0, 1'b1, 12'h400, 0));
        send_instr(make_instr(MODE_CPA, 1, 1, 1'b1, 0, 0));
        send_instr(make_instr(MODE_JNZ, 0, 0, 1'b1, 12'h200, 0));
        send_instr(make_instr(MODE_JZE, 0, 0, 1'b1, 4095, 0));
        send_instr(make_instr(MODE_START, 0, 0, 1'b1, 0, 0));
        send_instr(make_instr(MODE_CPA, 1, 0, 1'b0, 4095, 0));
        send_instr(make_instr(MODE_JPL, 0, 0, 1'b1, 12'h123, 0));
        send_instr(make_instr(MODE_JUMP, 0, 0, 1'b1, 4094, 0));
        send_instr(make_instr(MODE_LAD, 5, 0, 1'b1, 0, 16'h8000));
    endtask

    task automatic test_random_traffic(int count, int send_pct, int recv_pct);
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        repeat (count) begin
            send_instr(random_instr());
        end
    endtask

    // The receiver holds off for a long stretch while the sender keeps offering beats,
    // so the block fills up and has to drop s_tready.
    task automatic test_backpressure();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_cycles = HOLD_OFF_CYCLES;
        repeat (30) begin
            send_instr(random_instr());
        end
    endtask

    // Once RET has halted the machine nothing changes, memory writes included.
    task automatic test_halt();
        send_instr(make_instr(MODE_RET, 0, 0, 1'b1, 0, 0));
        repeat (24) begin
            send_instr(random_instr());
        end
        send_instr(make_instr(MODE_RET, 0, 0, 1'b1, 0, 0));
    endtask

    initial begin
        for (int i = 0; i < REGISTER_COUNT; i++) begin
            gpr[i] = '0;
        end
        for (int i = 0; i < MEMORY_WORDS; i++) begin
            dmem[i] = '0;
            mem_written[i] = 1'b0;
        end
        cpu_pc = '0;
        cpu_sign = 1'b0;
        cpu_zero = 1'b0;
        cpu_halt = 1'b0;

        repeat (11) @(negedge aclk);
        aresetn <= 1'b1;

        test_start_and_skip();
        test_load_store();
        test_arith_logic();
        test_shifts();
        test_compare_and_branch();
        test_random_traffic(170, 12, 53);
        test_random_traffic(170, 53, 12);
        test_random_traffic(130, 0, 0);
        test_backpressure();
        test_halt();

        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0) begin
            @(posedge aclk);
        end
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (error_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+rtl/core
rtl/core/casl_pkg.sv
rtl/core/casl_regfile.sv
rtl/core/casl_dmem.sv
rtl/core/casl_alu.sv
rtl/core/casl_instruction_executor.sv
rtl/core/casl_checker.sv
verif/casl_instruction_executor_tb.sv
